FILE: rtl/cursor_line_editor_top_assert.svh
// Assertion macros for the line editor checker
`ifndef CURSOR_LINE_EDITOR_TOP_ASSERT_SVH
`define CURSOR_LINE_EDITOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cle_pkg.sv
// Shared word types and key codes for the line editor
package cle_pkg;

	// Input word: func selects keystroke or read-out
	typedef struct packed {
		logic       func;
		logic [7:0] key_code;
	} in_word_t;

	// Output word: one character of a read-out, or the single word for an empty line
	typedef struct packed {
		logic [7:0] char_out;
		logic       char_valid;
		logic       last;
		logic [7:0] cursor_char;
		logic       overflow;
	} out_word_t;

	// Function codes
	localparam logic FUNC_KEY  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Command keys
	localparam logic [7:0] KEY_LEFT  = 8'h3C; // '<'
	localparam logic [7:0] KEY_RIGHT = 8'h3E; // '>'
	localparam logic [7:0] KEY_DEL   = 8'h23; // '#'
	localparam logic [7:0] KEY_BKSP  = 8'h40; // '@'
	localparam logic [7:0] KEY_HOME  = 8'h5E; // '^'
	localparam logic [7:0] KEY_END   = 8'h24; // '$'

	// Cursor character reported when the cursor sits past the last character
	localparam logic [7:0] AT_END_CH = 8'h30; // '0'

endpackage

FILE: rtl/cursor_line_editor_top.sv
// Line editor with cursor: moves and a dropped insert finish in idle. An insert shifts each
// character right of the cursor up one cell and a delete shifts each one after the removed
// cell down one; each shifted cell costs a read and a write through the character store, whose
// read data is registered. A read-out fetches the cursor character, then gives one word per
// character, holding while stalled; the input stays stalled until the last word is loaded.
// Reset clears length, cursor, overflow flag and state at once; the store is not cleared.
module cursor_line_editor_top import cle_pkg::*; #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_word_t  req_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_word_t rsp_word
);

	localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
	localparam int LW = $clog2(LINE_CAPACITY + 1);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	// Sequencer
	cle_seq #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.AW(AW),
		.LW(LW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word(req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word(rsp_word),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// Character store
	cle_mem #(
		.DEPTH(LINE_CAPACITY),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

FILE: rtl/cle_mem.sv
// Character store: one write port, one read port, registered read data
module cle_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] cells [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			cells[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= cells[raddr];
		end
	end

endmodule

FILE: rtl/cle_seq.sv
// Sequencer: decodes words, shifts cells through the store, streams read-outs
module cle_seq import cle_pkg::*; #(
	parameter int LINE_CAPACITY = 64,
	parameter int AW            = 6,
	parameter int LW            = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  in_word_t      req_word,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output out_word_t     rsp_word,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_CUR,
		ST_OUT_RD,
		ST_OUT_WR,
		ST_EMPTY
	} state_t;

	localparam logic [LW-1:0] CAP_L = LW'(LINE_CAPACITY);
	localparam logic [LW-1:0] ONE_L = LW'(1);

	state_t        state_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] idx_q;
	logic [7:0]    key_q;
	logic [7:0]    curch_q;
	logic          ovf_q;
	logic          ovfs_q;
	logic          rsp_valid_q;
	out_word_t     rsp_q;

	logic          accept;
	logic          out_free;
	logic          rsp_load;
	logic [LW-1:0] idx_m1;
	logic [LW-1:0] idx_p1;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = ((state_q == ST_OUT_WR) || (state_q == ST_EMPTY)) && out_free;
	assign idx_m1    = idx_q - ONE_L;
	assign idx_p1    = idx_q + ONE_L;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// Store accesses for the current step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				mem_re    = accept && (req_word.func == FUNC_READ);
				mem_raddr = cur_q[AW-1:0];
			end
			ST_INS_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idx_m1[AW-1:0];
			end
			ST_INS_WR: begin
				mem_we = 1'b1;
			end
			ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q[AW-1:0];
				mem_wdata = key_q;
			end
			ST_DEL_RD: begin
				mem_re    = (idx_q < len_q);
				mem_raddr = idx_p1[AW-1:0];
			end
			ST_DEL_WR: begin
				mem_we = 1'b1;
			end
			ST_OUT_RD: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State, line bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			key_q       <= '0;
			curch_q     <= '0;
			ovf_q       <= 1'b0;
			ovfs_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// output word loaded or taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_word.func == FUNC_READ) begin
							// flag snapshot for the whole read-out
							ovfs_q  <= ovf_q;
							ovf_q   <= 1'b0;
							state_q <= ST_CUR;
						end else begin
							unique case (req_word.key_code)
								KEY_LEFT: begin
									if (cur_q != '0) cur_q <= idx_m1 + cur_q - idx_q;
								end
								KEY_RIGHT: begin
									if (cur_q < len_q) cur_q <= cur_q + ONE_L;
								end
								KEY_DEL: begin
									if (cur_q < len_q) begin
										len_q   <= len_q - ONE_L;
										idx_q   <= cur_q;
										state_q <= ST_DEL_RD;
									end
								end
								KEY_BKSP: begin
									if (cur_q != '0) begin
										len_q   <= len_q - ONE_L;
										cur_q   <= cur_q - ONE_L;
										idx_q   <= cur_q - ONE_L;
										state_q <= ST_DEL_RD;
									end
								end
								KEY_HOME: begin
									cur_q <= '0;
								end
								KEY_END: begin
									cur_q <= len_q;
								end
								default: begin
									// insert before the cursor, or drop when full
									if (len_q == CAP_L) begin
										ovf_q <= 1'b1;
									end else begin
										key_q   <= req_word.key_code;
										idx_q   <= len_q;
										state_q <= (len_q != cur_q) ? ST_INS_RD : ST_INS_PUT;
									end
								end
							endcase
						end
					end
				end
				ST_INS_RD: begin
					state_q <= ST_INS_WR;
				end
				ST_INS_WR: begin
					// cell idx took cell idx-1; walk down toward the cursor
					idx_q   <= idx_m1;
					state_q <= (idx_m1 == cur_q) ? ST_INS_PUT : ST_INS_RD;
				end
				ST_INS_PUT: begin
					len_q   <= len_q + ONE_L;
					cur_q   <= cur_q + ONE_L;
					state_q <= ST_IDLE;
				end
				ST_DEL_RD: begin
					state_q <= (idx_q < len_q) ? ST_DEL_WR : ST_IDLE;
				end
				ST_DEL_WR: begin
					idx_q   <= idx_p1;
					state_q <= ST_DEL_RD;
				end
				ST_CUR: begin
					curch_q <= (cur_q < len_q) ? mem_rdata : AT_END_CH;
					idx_q   <= '0;
					state_q <= (len_q == '0) ? ST_EMPTY : ST_OUT_RD;
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_WR;
				end
				ST_OUT_WR: begin
					if (out_free) begin
						rsp_q.char_out    <= mem_rdata;
						rsp_q.char_valid  <= 1'b1;
						rsp_q.last        <= (idx_p1 == len_q);
						rsp_q.cursor_char <= curch_q;
						rsp_q.overflow    <= ovfs_q;
						idx_q             <= idx_p1;
						state_q           <= (idx_p1 == len_q) ? ST_IDLE : ST_OUT_RD;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						rsp_q.char_out    <= '0;
						rsp_q.char_valid  <= 1'b0;
						rsp_q.last        <= 1'b1;
						rsp_q.cursor_char <= curch_q;
						rsp_q.overflow    <= ovfs_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/cle_chk.sv
// Port-level checker for the line editor, bound to the top level
`include "cursor_line_editor_top_assert.svh"

module cle_chk import cle_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input in_word_t  req_word,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input out_word_t rsp_word
);

	logic in_take;
	logic rd_take;
	logic key_take;
	logic empty_word;
	logic empty_ok;

	assign in_take    = req_valid && !req_stall;
	assign rd_take    = in_take && (req_word.func == FUNC_READ);
	assign key_take   = in_take && (req_word.func == FUNC_KEY);
	assign empty_word = rsp_valid && !rsp_word.char_valid;
	assign empty_ok   = (rsp_word.char_out == 8'h00) && (rsp_word.cursor_char == AT_END_CH);

	// A stalled output word stays up
	`CLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "word dropped under stall")

	// A read-out request blocks the input while it streams
	`CLE_ASSERT_NEXT(a_read_stalls, rd_take, req_stall, "input not stalled after read")

	// An empty-line word is always the last one
	`CLE_ASSERT_NOW(a_empty_last, empty_word, rsp_word.last, "empty word not marked last")

	// An empty line has no character and the cursor stands at the end
	`CLE_ASSERT_NOW(a_empty_fields, empty_word, empty_ok, "bad fields in empty word")

	// A keystroke word never produces an output word
	`CLE_ASSERT_NEXT(a_key_silent, !rsp_valid && key_take, !rsp_valid, "word after keystroke")

endmodule

bind cursor_line_editor_top cle_chk u_cle_chk (.*);

FILE: verif/cursor_line_editor_checker.sv
// Checker for the line editor: watches both channels, predicts read-out words and compares them
module cursor_line_editor_checker import cle_pkg::*; #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  in_word_t  req_word,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  out_word_t rsp_word,
	output int        expected_count,
	output int        fail_count
);

	// Shadow copy of the line and its cursor
	logic [7:0] line_cells [LINE_CAPACITY];
	int         line_len;
	int         cursor_pos;
	logic       ovf_flag;

	// Read-out words still to come, oldest first
	out_word_t  readout_q [$];
	int         fails = 0;

	// One line per mismatch; the log is kept short, the count is not
	task automatic report_mismatch(input string what, input int want, input int got);
		if (fails < 100)
			$display("%0t mismatch %s: expected %0h, got %0h", $time, what, want, got);
		fails++;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got)
			report_mismatch(name, want, got);
	endtask

	// Drop the cell at idx and close the gap
	task automatic remove_cell(input int idx);
		int i;
		for (i = idx; i + 1 < line_len; i++)
			line_cells[i] = line_cells[i + 1];
		line_len--;
	endtask

	// Edit the shadow line with one keystroke
	task automatic apply_keystroke(input logic [7:0] k);
		int i;
		case (k)
			KEY_LEFT: if (cursor_pos > 0) cursor_pos--;
			KEY_RIGHT: if (cursor_pos < line_len) cursor_pos++;
			KEY_DEL: if (cursor_pos < line_len) remove_cell(cursor_pos);
			KEY_BKSP: begin
				if (cursor_pos > 0) begin
					remove_cell(cursor_pos - 1);
					cursor_pos--;
				end
			end
			KEY_HOME: cursor_pos = 0;
			KEY_END: cursor_pos = line_len;
			default: begin
				// full line drops the byte and latches overflow
				if (line_len >= LINE_CAPACITY) begin
					ovf_flag = 1'b1;
				end else begin
					for (i = line_len; i > cursor_pos; i--)
						line_cells[i] = line_cells[i - 1];
					line_cells[cursor_pos] = k;
					line_len++;
					cursor_pos++;
				end
			end
		endcase
	endtask

	// Queue the words of one read-out; every word carries the flag from before the read
	task automatic queue_readout();
		out_word_t  w;
		logic [7:0] under;
		int         i;
		under = (cursor_pos < line_len) ? line_cells[cursor_pos] : AT_END_CH;
		w.cursor_char = under;
		w.overflow    = ovf_flag;
		if (line_len == 0) begin
			// empty line: a single word marked not valid
			w.char_out   = 8'h00;
			w.char_valid = 1'b0;
			w.last       = 1'b1;
			readout_q    = {readout_q, w};
		end else begin
			for (i = 0; i < line_len; i++) begin
				w.char_out   = line_cells[i];
				w.char_valid = 1'b1;
				w.last       = (i + 1 == line_len);
				readout_q    = {readout_q, w};
			end
		end
		ovf_flag = 1'b0;
	endtask

	// Compare one accepted word with the oldest expectation
	task automatic check_word(input out_word_t got);
		out_word_t want;
		if (readout_q.size() == 0) begin
			report_mismatch("word with nothing pending", 0, int'(got));
		end else begin
			want = readout_q.pop_front();
			check_field("char_out", int'(want.char_out), int'(got.char_out));
			check_field("char_valid", int'(want.char_valid), int'(got.char_valid));
			check_field("last", int'(want.last), int'(got.last));
			check_field("cursor_char", int'(want.cursor_char), int'(got.cursor_char));
			check_field("overflow", int'(want.overflow), int'(got.overflow));
		end
	endtask

	// Sample both channels at the edge where words are taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len   = 0;
			cursor_pos = 0;
			ovf_flag   = 1'b0;
			readout_q.delete();
			expected_count <= 0;
			fail_count     <= fails;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_word(rsp_word);
			if (req_valid && !req_stall) begin
				if (req_word.func == FUNC_READ)
					queue_readout();
				else
					apply_keystroke(req_word.key_code);
			end
			expected_count <= readout_q.size();
			fail_count     <= fails;
		end
	end

endmodule

FILE: verif/tb_cursor_line_editor_top.sv
// Testbench top for the line editor: clock, reset, keystroke and read stimulus, verdict
module tb_cursor_line_editor_top;
	import cle_pkg::*;

	localparam int LINE_CAPACITY = 64;
	localparam int ITEM_TARGET   = 320;
	localparam int HOLD_CYCLES   = 400;
	localparam int TAIL_CYCLES   = 300;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	in_word_t  req_word;
	logic      rsp_valid;
	logic      rsp_stall;
	out_word_t rsp_word;
	int        expected_count;
	int        fail_count;

	int        items_sent  = 0;
	int        no_gap_left = 0;
	int        hold_req    = 0;
	int        hold_done   = 0;

	cursor_line_editor_top #(.LINE_CAPACITY(LINE_CAPACITY)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	cursor_line_editor_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_word       (req_word),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp_word       (rsp_word),
		.expected_count (expected_count),
		.fail_count     (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#80000000;
		$display("tb_cursor_line_editor_top NOT OK");
		$finish;
	end

	// Idle length: mostly none or short, a few long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] pick_command();
		case ($urandom_range(0, 5))
			0: return KEY_LEFT;
			1: return KEY_RIGHT;
			2: return KEY_DEL;
			3: return KEY_BKSP;
			4: return KEY_HOME;
			default: return KEY_END;
		endcase
	endfunction

	// Random byte that is inserted rather than taken as a command
	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c == KEY_LEFT || c == KEY_RIGHT || c == KEY_DEL || c == KEY_BKSP ||
			c == KEY_HOME || c == KEY_END);
		return c;
	endfunction

	// Offer one word and hold it until taken
	task automatic send_word(input logic f, input logic [7:0] k);
		int gap;
		gap = (no_gap_left > 0) ? 0 : pick_idle();
		if (no_gap_left > 0)
			no_gap_left--;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid         <= 1'b1;
		req_word.func     <= f;
		req_word.key_code <= k;
		do
			@(posedge clk);
		while (req_stall);
		items_sent++;
	endtask

	task automatic key_in(input logic [7:0] k);
		send_word(FUNC_KEY, k);
	endtask

	task automatic read_line(input logic [7:0] k);
		send_word(FUNC_READ, k);
	endtask

	// Stop offering until every pending read-out word has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_count != 0)
			@(posedge clk);
	endtask

	// Type past the capacity so the overflow flag gets set
	task automatic fill_line();
		repeat (LINE_CAPACITY + 2) key_in(pick_char());
	endtask

	// Receiver: random stall pattern, plus one long hold-off on request
	initial begin
		int n;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_done != hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
				rsp_stall <= 1'b0;
				repeat (n) @(posedge clk);
				n = pick_idle();
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int kind;
		int n;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_word  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: edges on an empty line, extreme bytes, each command, ignored key on read
		read_line(8'hFF);
		key_in(KEY_LEFT);
		key_in(KEY_BKSP);
		key_in(KEY_DEL);
		key_in(KEY_RIGHT);
		key_in(8'h00);
		key_in(8'hFF);
		key_in(8'h41);
		key_in(KEY_HOME);
		read_line(8'h00);
		key_in(KEY_RIGHT);
		key_in(KEY_DEL);
		key_in(KEY_END);
		key_in(KEY_DEL);
		key_in(KEY_RIGHT);
		read_line(8'h5A);
		key_in(KEY_LEFT);
		key_in(KEY_BKSP);
		key_in(AT_END_CH);
		key_in(KEY_HOME);
		read_line(8'hA5);
		read_line(8'h00);

		// Full line with overflow, then a long receiver hold-off while reads keep coming
		fill_line();
		hold_req++;
		read_line(8'($urandom));
		key_in(pick_char());
		read_line(8'($urandom));
		key_in(KEY_HOME);
		read_line(8'($urandom));
		drain();

		// Random sequences, mostly well-formed editing with some noise
		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				n = $urandom_range(1, 8);
				repeat (n) key_in(pick_char());
			end else if (kind < 55) begin
				key_in(pick_command());
			end else if (kind < 63) begin
				key_in(8'($urandom));
			end else if (kind < 80) begin
				read_line(8'($urandom));
			end else if (kind < 88) begin
				key_in(($urandom_range(0, 1) != 0) ? KEY_HOME : KEY_END);
				n = $urandom_range(1, 6);
				repeat (n) key_in(($urandom_range(0, 1) != 0) ? KEY_DEL : KEY_BKSP);
			end else if (kind < 91) begin
				// erase most or all of the line from the end
				key_in(KEY_END);
				n = $urandom_range(10, 40);
				repeat (n) key_in(KEY_BKSP);
			end else if (kind < 93) begin
				fill_line();
				read_line(8'($urandom));
			end else if (kind < 96) begin
				drain();
			end else begin
				no_gap_left = $urandom_range(10, 30);
			end
		end
		read_line(8'($urandom));

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_count == 0)
			$display("tb_cursor_line_editor_top OK");
		else
			$display("tb_cursor_line_editor_top NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cle_pkg.sv
rtl/cle_mem.sv
rtl/cle_seq.sv
rtl/cursor_line_editor_top.sv
rtl/cle_chk.sv
verif/cursor_line_editor_checker.sv
verif/tb_cursor_line_editor_top.sv
